// ----- hw/rtl/largest_twin_prime_in_range_unit_defines.svh -----
// Assertion macros shared by the largest twin prime search unit.
`ifndef LARGEST_TWIN_PRIME_IN_RANGE_UNIT_DEFINES_SVH
`define LARGEST_TWIN_PRIME_IN_RANGE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LTP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ltp_pkg.sv -----
// Package with the payload, command and status types of the twin prime search unit.
`timescale 1ns / 1ps

package ltp_pkg;

  localparam int VALUE_WIDTH = 16;
  // Test values carry two extra bits so that the plus-two neighbor never wraps.
  localparam int NWIDTH      = VALUE_WIDTH + 2;
  localparam int CNT_WIDTH   = $clog2(NWIDTH);

  localparam logic [NWIDTH-1:0]    N_ONE    = NWIDTH'(1);
  localparam logic [NWIDTH-1:0]    N_TWO    = NWIDTH'(2);
  localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(NWIDTH - 1);

  localparam logic [1:0] SEL_SELF  = 2'd0;
  localparam logic [1:0] SEL_MINUS = 2'd1;
  localparam logic [1:0] SEL_PLUS  = 2'd2;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] range_low;
    logic [VALUE_WIDTH-1:0] range_high;
  } in_t;

  typedef struct packed {
    logic                   found;
    logic [VALUE_WIDTH-1:0] twin_prime;
  } out_t;

  typedef struct packed {
    logic       load_range;
    logic       cand_dec;
    logic       load_n;
    logic [1:0] n_sel;
    logic       div_start;
    logic       div_step;
    logic       d_inc;
    logic       res_load;
    logic       res_found;
  } cmd_t;

  typedef struct packed {
    logic range_empty;
    logic cand_is_lo;
    logic n_lt2;
    logic d_sq_gt_n;
    logic div_done;
    logic rem_zero;
  } sts_t;

endpackage

// ----- hw/rtl/ltp_ctrl.sv -----
// Controller state machine that sequences the candidate scan and trial division.
`timescale 1ns / 1ps

module ltp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  input  ltp_pkg::sts_t sts,
  output ltp_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RANGE = 4'd1;
  localparam logic [3:0] S_LOADN = 4'd2;
  localparam logic [3:0] S_SMALL = 4'd3;
  localparam logic [3:0] S_BOUND = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_REM   = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_HIT   = 4'd8;
  localparam logic [3:0] S_MISS  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] sel;
  logic [1:0] sel_next;
  logic       rsp_valid_next;
  logic       v_valid;
  logic       v_prime;
  logic       out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next     = state;
    sel_next       = sel;
    cmd            = '0;
    v_valid        = 1'b0;
    v_prime        = 1'b0;
    rsp_valid_next = rsp_valid && rsp_stall;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_range = 1'b1;
          state_next     = S_RANGE;
        end
      end
      S_RANGE: begin
        if (sts.range_empty) begin
          state_next = S_MISS;
        end else begin
          sel_next   = ltp_pkg::SEL_SELF;
          state_next = S_LOADN;
        end
      end
      S_LOADN: begin
        cmd.load_n = 1'b1;
        cmd.n_sel  = sel;
        state_next = S_SMALL;
      end
      S_SMALL: begin
        if (sts.n_lt2) begin
          v_valid = 1'b1;
        end else begin
          state_next = S_BOUND;
        end
      end
      S_BOUND: begin
        if (sts.d_sq_gt_n) begin
          v_valid = 1'b1;
          v_prime = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_REM;
        end
      end
      S_REM: begin
        if (sts.rem_zero) begin
          v_valid = 1'b1;
        end else begin
          cmd.d_inc  = 1'b1;
          state_next = S_BOUND;
        end
      end
      S_NEXT: begin
        if (sts.cand_is_lo) begin
          state_next = S_MISS;
        end else begin
          cmd.cand_dec = 1'b1;
          sel_next     = ltp_pkg::SEL_SELF;
          state_next   = S_LOADN;
        end
      end
      S_HIT, S_MISS: begin
        if (out_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_found  = (state == S_HIT);
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (v_valid) begin
      unique case (sel)
        ltp_pkg::SEL_SELF: begin
          if (v_prime) begin
            sel_next   = ltp_pkg::SEL_MINUS;
            state_next = S_LOADN;
          end else begin
            state_next = S_NEXT;
          end
        end
        ltp_pkg::SEL_MINUS: begin
          if (v_prime) begin
            state_next = S_HIT;
          end else begin
            sel_next   = ltp_pkg::SEL_PLUS;
            state_next = S_LOADN;
          end
        end
        ltp_pkg::SEL_PLUS: begin
          state_next = v_prime ? S_HIT : S_NEXT;
        end
        default: begin
          state_next = S_NEXT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= ltp_pkg::SEL_SELF;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sel       <= sel_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ----- hw/rtl/ltp_dp.sv -----
// Datapath with the candidate, trial divisor, restoring remainder unit and result register.
`timescale 1ns / 1ps

module ltp_dp (
  input  logic          clk,
  input  ltp_pkg::in_t  req_data,
  input  ltp_pkg::cmd_t cmd,
  output ltp_pkg::sts_t sts,
  output ltp_pkg::out_t rsp_data
);

  localparam int NW = ltp_pkg::NWIDTH;
  localparam int VW = ltp_pkg::VALUE_WIDTH;

  logic [VW-1:0]                  lo;
  logic [VW-1:0]                  cand;
  logic [NW-1:0]                  n;
  logic [NW-1:0]                  d;
  logic [NW-1:0]                  rem;
  logic [NW-1:0]                  qsh;
  logic [ltp_pkg::CNT_WIDTH-1:0]  cnt;
  logic [NW-1:0]                  cand_ext;
  logic [NW-1:0]                  n_sel_val;
  logic [2*NW-1:0]                d_sq;
  logic [NW:0]                    trial;
  logic [NW:0]                    diff;
  logic                           trial_ge;

  assign cand_ext = {2'b00, cand};

  always_comb begin
    unique case (cmd.n_sel)
      ltp_pkg::SEL_MINUS: n_sel_val = cand_ext - ltp_pkg::N_TWO;
      ltp_pkg::SEL_PLUS:  n_sel_val = cand_ext + ltp_pkg::N_TWO;
      default:            n_sel_val = cand_ext;
    endcase
  end

  assign d_sq     = d * d;
  assign trial    = {rem, qsh[NW-1]};
  assign diff     = trial - {1'b0, d};
  assign trial_ge = (trial >= {1'b0, d});

  assign sts.range_empty = (lo > cand);
  assign sts.cand_is_lo  = (cand == lo);
  assign sts.n_lt2       = (n < ltp_pkg::N_TWO);
  assign sts.d_sq_gt_n   = (d_sq > {{NW{1'b0}}, n});
  assign sts.div_done    = (cnt == ltp_pkg::CNT_LAST);
  assign sts.rem_zero    = (rem == '0);

  always_ff @(posedge clk) begin
    if (cmd.load_range) begin
      lo   <= req_data.range_low;
      cand <= req_data.range_high;
    end else if (cmd.cand_dec) begin
      cand <= cand - VW'(1);
    end

    if (cmd.load_n) begin
      n <= n_sel_val;
      d <= ltp_pkg::N_TWO;
    end else if (cmd.d_inc) begin
      d <= d + ltp_pkg::N_ONE;
    end

    if (cmd.div_start) begin
      rem <= '0;
      qsh <= n;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? diff[NW-1:0] : trial[NW-1:0];
      qsh <= {qsh[NW-2:0], 1'b0};
      cnt <= cnt + ltp_pkg::CNT_WIDTH'(1);
    end

    if (cmd.res_load) begin
      rsp_data.found      <= cmd.res_found;
      rsp_data.twin_prime <= cmd.res_found ? cand : '0;
    end
  end

endmodule

// ----- hw/rtl/largest_twin_prime_in_range_unit.sv -----
// Top level of the largest twin prime search unit: controller, datapath and checks.
//
// The unit takes one transaction holding a low and a high bound and returns one
// transaction holding found and the largest twin prime in the inclusive range,
// scanning downward from the high bound. It works on one range at a time and
// stalls its request side until the result is loaded. Each candidate is checked
// by trial division with divisors from 2 while the divisor squared does not
// exceed the tested value; every divisor tried takes a bound check, 18 remainder
// steps of the bit-serial restoring remainder unit and a remainder check. A
// tested value below two is rejected after the load and small-value check; any
// other goes through the same setup, the divisors tried, and one more bound
// check when it turns out to be prime. A candidate tests itself and, when prime,
// its minus-two neighbor and, when that one is not prime, its plus-two neighbor.
// Each candidate that is not reported passes through a step-down state. After
// the accepting edge, a range check, the scan, and a state that loads the result
// once the response side is free come before the result is valid; an empty
// range skips the scan, and the time depends on the data. A new range may be
// accepted while the previous result still waits on the response side.
`timescale 1ns / 1ps
`include "largest_twin_prime_in_range_unit_defines.svh"

module largest_twin_prime_in_range_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ltp_pkg::in_t  req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ltp_pkg::out_t rsp_data
);

  ltp_pkg::cmd_t cmd;
  ltp_pkg::sts_t sts;

  ltp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ltp_dp u_dp (
    .clk      (clk),
    .req_data (req_data),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_data (rsp_data)
  );

  `LTP_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.res_load, !(rsp_valid && rsp_stall), "result loaded over a waiting transaction")
  `LTP_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall, "request side not stalled after an accepted transaction")
  `LTP_ASSERT_NOW(a_miss_is_zero, clk, rst, rsp_valid && !rsp_data.found, rsp_data.twin_prime == '0, "value nonzero when no twin prime was found")
  `LTP_ASSERT_NOW(a_no_dec_past_low, clk, rst, cmd.cand_dec, !sts.cand_is_lo, "candidate decremented below the low bound")

endmodule

// ----- sim/tb_largest_twin_prime_in_range_unit.sv -----
// Self-checking testbench for the largest twin prime search unit with a scoreboard class.
`timescale 1ns / 1ps

module tb_largest_twin_prime_in_range_unit;

  localparam int          VW             = ltp_pkg::VALUE_WIDTH;
  localparam int unsigned VALUE_MAX      = (1 << VW) - 1;
  localparam int unsigned WATCHDOG_LIMIT = 3_000_000;
  localparam int unsigned HOLDOFF_CYCLES = 3000;
  localparam int unsigned DRAIN_CYCLES   = 100;

  class twin_prime_board;
    ltp_pkg::out_t expected_twins[$];
    int            failures;

    function new();
      failures = 0;
    endfunction

    static function bit is_prime(int unsigned n);
      int unsigned d;
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    static function bit is_twin(int unsigned n);
      if (!is_prime(n)) return 1'b0;
      if (n >= 2 && is_prime(n - 2)) return 1'b1;
      return is_prime(n + 2);
    endfunction

    static function ltp_pkg::out_t largest_twin(ltp_pkg::in_t r);
      ltp_pkg::out_t res;
      int unsigned lo;
      int unsigned hi;
      int unsigned cand;
      res = '0;
      lo = 32'(r.range_low);
      hi = 32'(r.range_high);
      if (lo > hi) return res;
      cand = hi;
      forever begin
        if (is_twin(cand)) begin
          res.found = 1'b1;
          res.twin_prime = VW'(cand);
          return res;
        end
        if (cand == lo) return res;
        cand--;
      end
    endfunction

    function void note_range(ltp_pkg::in_t r);
      expected_twins.push_back(largest_twin(r));
    endfunction

    function void check_result(ltp_pkg::out_t got);
      ltp_pkg::out_t want;
      if (expected_twins.size() == 0) begin
        $display("%0t: unexpected result transaction found=%0b twin_prime=%0d",
                 $time, got.found, got.twin_prime);
        failures++;
        return;
      end
      want = expected_twins.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found mismatch, expected %0b, actual %0b",
                 $time, want.found, got.found);
        failures++;
      end
      if (got.twin_prime !== want.twin_prime) begin
        $display("%0t: twin_prime mismatch, expected %0d, actual %0d",
                 $time, want.twin_prime, got.twin_prime);
        failures++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          req_valid;
  logic          req_stall;
  ltp_pkg::in_t  req_data;
  logic          rsp_valid;
  logic          rsp_stall;
  ltp_pkg::out_t rsp_data;

  twin_prime_board board = new();
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 64;
  int unsigned holdoffs_asked = 0;
  int unsigned holdoffs_done = 0;

  ltp_pkg::in_t directed_ranges[$] = '{
    '{16'd0, 16'd0}, '{16'd1, 16'd1}, '{16'd2, 16'd2}, '{16'd3, 16'd3},
    '{16'd4, 16'd4}, '{16'd5, 16'd5}, '{16'd0, 16'd2}, '{16'd0, 16'd3},
    '{16'd24, 16'd28}, '{16'd7, 16'd7}, '{16'd1, 16'd0}, '{16'd65535, 16'd0},
    '{16'd65535, 16'd65535}, '{16'd65521, 16'd65535}, '{16'd0, 16'd65535},
    '{16'd43690, 16'd21845}, '{16'd21845, 16'd43690}, '{16'd32768, 16'd32800},
    '{16'd100, 16'd100}, '{16'd0, 16'd1}
  };

  largest_twin_prime_in_range_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (req_valid && !req_stall) board.note_range(req_data);
      if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The receiver either stalls at random or holds off for a long stretch on request.
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoffs_asked != holdoffs_done) begin
        rsp_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoffs_done++;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_range(input ltp_pkg::in_t r);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic send_random(input int count);
    ltp_pkg::in_t r;
    int unsigned hi;
    int unsigned lo;
    int unsigned kind;
    repeat (count) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        hi = $urandom_range(VALUE_MAX - 1);
        lo = $urandom_range(VALUE_MAX, hi + 1);
      end else if (kind < 25) begin
        hi = $urandom_range(VALUE_MAX, 1024);
        lo = hi - $urandom_range(255);
      end else if (kind < 60) begin
        hi = $urandom_range(1023);
        lo = $urandom_range(hi);
      end else begin
        hi = $urandom_range(1023);
        lo = hi - $urandom_range(hi < 40 ? hi : 40);
      end
      r.range_low  = VW'(lo);
      r.range_high = VW'(hi);
      send_range(r);
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (board.expected_twins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    ltp_pkg::in_t r;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_ranges[i]) send_range(directed_ranges[i]);
    send_random(25);
    wait_drained();

    send_idle_pct = 64;
    recv_idle_pct <= 10;
    send_random(30);
    wait_drained();

    // While the receiver holds off, short searches fill the unit until it stalls.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    holdoffs_asked <= holdoffs_asked + 1;
    repeat (5) begin
      r.range_low  = VW'($urandom_range(3));
      r.range_high = VW'($urandom_range(20, 5));
      send_range(r);
    end
    send_random(25);
    wait_drained();

    if (board.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- largest_twin_prime_in_range_unit.f -----
+incdir+hw/rtl
hw/rtl/ltp_pkg.sv
hw/rtl/ltp_ctrl.sv
hw/rtl/ltp_dp.sv
hw/rtl/largest_twin_prime_in_range_unit.sv
sim/tb_largest_twin_prime_in_range_unit.sv
